@@ src/gcd_pkg.sv @@
// ============================================================================
// gcd_pkg
// Shared types and constants of the great-circle distance core: fixed-point
// constants, CORDIC angle table, pipeline latencies and the queue item type.
// ============================================================================
package gcd_pkg;

    // Angle scale and arithmetic constants.
    localparam int ANGLE_FRAC_BITS_DEF = 20;
    localparam logic [31:0] TURN_PER_DEG_Q40 = 32'd3054198966;
    localparam logic [30:0] PI_Q29 = 31'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;
    localparam logic [25:0] DIST_MAX = 26'h3FFFFFF;
    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

    // Pipeline shape.
    localparam int CORDIC_ITERS = 31;
    localparam int SQRT_STEPS = 32;
    localparam int ROT_LAT = CORDIC_ITERS + 1;
    localparam int MUL_LAT = 4;
    localparam int SQRT_LAT = SQRT_STEPS;
    localparam int VEC_LAT = CORDIC_ITERS;
    localparam int POST_LAT = 3;
    localparam int BACK_LAT = ROT_LAT + MUL_LAT + SQRT_LAT + VEC_LAT + POST_LAT;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Arctangent of 2^-i in binary-angle units (2^32 is one turn).
    localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

    // One word in the queue: the four binary angles of a point pair.
    typedef struct packed {
        logic [31:0] lat1;
        logic [31:0] lat2;
        logic [31:0] half_dlat;
        logic [31:0] half_dlon;
    } angles_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic                valid;
        logic                room;
        logic [QUEUE_CW-1:0] count;
    } q_stat_t;

endpackage

@@ src/gcd_if.sv @@
// ============================================================================
// gcd_if
// Valid/ready channels of the great-circle distance core: point pairs in,
// distances out, and the radius configuration write.
// ============================================================================
interface gcd_pair_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] ref_lat;
    logic signed [28:0] ref_lon;
    logic signed [27:0] comp_lat;
    logic signed [28:0] comp_lon;

    modport source (output valid, ref_lat, ref_lon, comp_lat, comp_lon, input ready);
    modport sink (input valid, ref_lat, ref_lon, comp_lat, comp_lon, output ready);
endinterface

interface gcd_dist_if;
    logic        valid;
    logic        ready;
    logic [25:0] distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink (input valid, distance_m, output ready);
endinterface

interface gcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] sphere_radius_m;

    modport source (output valid, sphere_radius_m, input ready);
    modport sink (input valid, sphere_radius_m, output ready);
endinterface

@@ src/great_circle_distance_core.sv @@
// ============================================================================
// great_circle_distance_core
// Haversine great-circle distance between two points given in fixed-point
// degrees, in whole metres on a sphere of programmable radius.
// ============================================================================
//
// Channel   Direction  Word
// pair      in         ref_lat, ref_lon, comp_lat, comp_lon (deg * 2^frac)
// result    out        distance_m, saturated at 2^26-1
// cfg       in         sphere_radius_m, reset 6371000
//
// One pair is accepted per cycle while the queue has room. The conversion
// stage loads on the accepting edge, the queue in the cycle after, then a
// 102-stage back pipeline made of the CORDIC, square-root and multiplier
// stages.
// Reset clears the queue, the valid bits and sets the radius to 6371000.
// A stalled output freezes the back pipeline; the front keeps filling the
// four-word queue until it is full.
// ============================================================================
module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    gcd_pair_if.sink    pair,
    gcd_dist_if.source  result,
    gcd_cfg_if.sink     cfg
);

    logic              push;
    logic              pop;
    gcd_pkg::angles_t  push_data;
    gcd_pkg::angles_t  head;
    gcd_pkg::q_stat_t  q_stat;
    logic [23:0]       radius_reg;

    // Radius register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= gcd_pkg::RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            radius_reg <= cfg.sphere_radius_m;
        end
    end

    gcd_front #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .pair(pair),
        .q_stat(q_stat),
        .push(push),
        .push_data(push_data)
    );

    gcd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .pop(pop),
        .head(head),
        .stat(q_stat)
    );

    gcd_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .q_stat(q_stat),
        .pop(pop),
        .radius(radius_reg),
        .result(result)
    );

    // The queue never holds more words than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= gcd_pkg::QUEUE_CW'(gcd_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // The back only takes a word that is there.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.count != '0)
        else $error("pop from empty queue");

    // A pair is only accepted while the queue keeps room for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && pair.ready)
            |-> q_stat.count <= gcd_pkg::QUEUE_CW'(gcd_pkg::QUEUE_DEPTH - 2))
        else $error("pair accepted without queue room");

endmodule

@@ src/gcd_front.sv @@
// ============================================================================
// gcd_front
// Accepts point pairs and turns the latitudes and half differences into
// 32-bit binary angles, one word per cycle into the queue while it has room.
// ============================================================================
module gcd_front #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    gcd_pair_if.sink          pair,
    input  gcd_pkg::q_stat_t  q_stat,
    output logic              push,
    output gcd_pkg::angles_t  push_data
);

    localparam int SH_ABS = ANGLE_FRAC_BITS + 8;
    localparam int SH_HALF = ANGLE_FRAC_BITS + 9;

    logic               f_valid_reg;
    logic [61:0]        prod_reg [4];
    logic [3:0]         neg_reg;
    logic signed [29:0] val [4];
    logic [29:0]        mag [4];
    logic [31:0]        turn [4];
    logic [63:0]        rsum;
    logic [63:0]        rsh;

    // The queue keeps room for the word in flight and one more.
    assign pair.ready = q_stat.room;

    // Signed values to convert; differences are one bit wider.
    always_comb
    begin
        val[0] = 30'(pair.ref_lat);
        val[1] = 30'(pair.comp_lat);
        val[2] = 30'(pair.comp_lat) - 30'(pair.ref_lat);
        val[3] = 30'(pair.comp_lon) - 30'(pair.ref_lon);
        for (int k = 0; k < 4; k++)
        begin
            mag[k] = val[k][29] ? 30'(-val[k]) : 30'(val[k]);
        end
    end

    // Stage one: scale magnitudes to turns.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= 62'(mag[k]) * 62'(gcd_pkg::TURN_PER_DEG_Q40);
            neg_reg[k]  <= val[k][29];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= pair.valid && pair.ready;
        end
    end

    // Stage two: round half up, drop the scale, restore the sign.
    always_comb
    begin
        rsum = '0;
        rsh  = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (k < 2)
            begin
                rsum = {2'b00, prod_reg[k]} + (64'd1 << (SH_ABS - 1));
                rsh  = rsum >> SH_ABS;
            end
            else
            begin
                rsum = {2'b00, prod_reg[k]} + (64'd1 << (SH_HALF - 1));
                rsh  = rsum >> SH_HALF;
            end
            turn[k] = neg_reg[k] ? 32'(-rsh[31:0]) : rsh[31:0];
        end
    end

    assign push                = f_valid_reg;
    assign push_data.lat1      = turn[0];
    assign push_data.lat2      = turn[1];
    assign push_data.half_dlat = turn[2];
    assign push_data.half_dlon = turn[3];

endmodule

@@ src/gcd_queue.sv @@
// ============================================================================
// gcd_queue
// Short first-in first-out queue of angle words between the front and the
// back, so that either side can stall on its own.
// ============================================================================
module gcd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gcd_pkg::angles_t  push_data,
    input  logic              pop,
    output gcd_pkg::angles_t  head,
    output gcd_pkg::q_stat_t  stat
);

    gcd_pkg::angles_t                  mem_reg [gcd_pkg::QUEUE_DEPTH];
    logic [gcd_pkg::QUEUE_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [gcd_pkg::QUEUE_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [gcd_pkg::QUEUE_CW-1:0]      count_reg, count_next;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gcd_pkg::QUEUE_CW'(push) - gcd_pkg::QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.room  = (count_reg <= gcd_pkg::QUEUE_CW'(gcd_pkg::QUEUE_DEPTH - 2));
    assign stat.count = count_reg;

endmodule

@@ src/gcd_rot.sv @@
// ============================================================================
// gcd_rot
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle in Q30,
// one stage per iteration after a quadrant folding stage.
// ============================================================================
module gcd_rot (
    input  logic                     clk,
    input  logic                     en,
    input  logic [31:0]              ang,
    output logic signed [33:0]       cos_q30,
    output logic signed [33:0]       sin_q30
);

    localparam int N = gcd_pkg::CORDIC_ITERS;

    logic signed [33:0] x_reg [N+1];
    logic signed [33:0] y_reg [N+1];
    logic signed [33:0] z_reg [N+1];
    logic               flip_reg [N+1];
    logic signed [33:0] z_in;
    logic signed [33:0] z_fold;
    logic               flip_in;

    // Fold the angle into the right half plane.
    always_comb
    begin
        z_in    = 34'($signed(ang));
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > 34'sd1073741824)
        begin
            z_fold  = z_in - 34'sd2147483648;
            flip_in = 1'b1;
        end
        else if (z_in < -34'sd1073741824)
        begin
            z_fold  = z_in + 34'sd2147483648;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= gcd_pkg::CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [33:0] atn;
        assign atn = 34'(gcd_pkg::ATAN_TURNS[i]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atn;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atn;
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign cos_q30 = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_q30 = flip_reg[N] ? -y_reg[N] : y_reg[N];

endmodule

@@ src/gcd_sqrt.sv @@
// ============================================================================
// gcd_sqrt
// Pipelined exact integer square root, one result bit per stage.
// ============================================================================
module gcd_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int N = gcd_pkg::SQRT_STEPS;

    logic [63:0] v_reg [N];
    logic [63:0] r_reg [N];
    logic [63:0] v_in  [N];
    logic [63:0] r_in  [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;

        if (k == 0)
        begin : g_first
            assign v_in[k] = radicand;
            assign r_in[k] = '0;
        end
        else
        begin : g_next
            assign v_in[k] = v_reg[k-1];
            assign r_in[k] = r_reg[k-1];
        end

        // Subtract the trial value when it fits.
        assign trial = r_in[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_in[k] >= trial)
                begin
                    v_reg[k] <= v_in[k] - trial;
                    r_reg[k] <= (r_in[k] >> 1) + BIT;
                end
                else
                begin
                    v_reg[k] <= v_in[k];
                    r_reg[k] <= r_in[k] >> 1;
                end
            end
        end
    end

    assign root = r_reg[N-1][31:0];

endmodule

@@ src/gcd_back.sv @@
// ============================================================================
// gcd_back
// Carries out the haversine: four sine/cosine units, the product chain for a,
// two square roots, a vectoring CORDIC for atan2 and the scaling to metres.
// The whole pipeline moves when its output register is free or being taken.
// ============================================================================
module gcd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  gcd_pkg::angles_t  head,
    input  gcd_pkg::q_stat_t  q_stat,
    output logic              pop,
    input  logic [23:0]       radius,
    gcd_dist_if.source        result
);

    localparam int L = gcd_pkg::BACK_LAT;
    localparam int NV = gcd_pkg::CORDIC_ITERS;

    logic [L-1:0]       vld_reg, vld_next;
    logic               en;
    logic signed [33:0] c1, s1, c2, s2, cd, sd, co, so;

    logic [31:0]        c1m, c2m, sdm, som;
    logic               neg;
    logic [63:0]        pcc_reg, sd2_reg, sd2b_reg, sd2c_reg;
    logic [31:0]        so1_reg, so2_reg;
    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [63:0]        tp_reg, term_reg;
    logic [63:0]        ccq_sum, t_sum;
    logic signed [65:0] a_s;
    logic [63:0]        a_reg, b_reg;
    logic [31:0]        sa, sb;

    logic signed [33:0] vx_reg [NV];
    logic signed [33:0] vy_reg [NV];
    logic signed [33:0] vz_reg [NV];
    logic signed [33:0] vx_in [NV];
    logic signed [33:0] vy_in [NV];
    logic signed [33:0] vz_in [NV];

    logic [31:0]        th;
    logic [63:0]        pp_reg, dp_reg, cq_sum, d_sum;
    logic [25:0]        dist_reg;

    // Advance when the output register is empty or taken.
    assign en  = !vld_reg[L-1] || result.ready;
    assign pop = en && q_stat.valid;

    always_comb
    begin
        vld_next = en ? {vld_reg[L-2:0], pop} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Sines and cosines of the four angles.
    gcd_rot u_rot_lat1 (.clk(clk), .en(en), .ang(head.lat1), .cos_q30(c1), .sin_q30(s1));
    gcd_rot u_rot_lat2 (.clk(clk), .en(en), .ang(head.lat2), .cos_q30(c2), .sin_q30(s2));
    gcd_rot u_rot_dlat (.clk(clk), .en(en), .ang(head.half_dlat), .cos_q30(cd), .sin_q30(sd));
    gcd_rot u_rot_dlon (.clk(clk), .en(en), .ang(head.half_dlon), .cos_q30(co), .sin_q30(so));

    // Magnitudes and the sign of the cosine product.
    always_comb
    begin
        c1m = c1[33] ? 32'(-c1) : 32'(c1);
        c2m = c2[33] ? 32'(-c2) : 32'(c2);
        sdm = sd[33] ? 32'(-sd) : 32'(sd);
        som = so[33] ? 32'(-so) : 32'(so);
        neg = (c1[33] != c2[33]) && (c1 != '0) && (c2 != '0);
    end

    // Product chain for a, its multiplies spread over the stages.
    always_comb
    begin
        ccq_sum = pcc_reg + (64'd1 << 29);
        t_sum   = tp_reg + (64'd1 << 29);
        a_s     = neg3_reg ? 66'(sd2c_reg) - 66'(term_reg) : 66'(sd2c_reg) + 66'(term_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc_reg  <= 64'(c1m) * 64'(c2m);
            sd2_reg  <= 64'(sdm) * 64'(sdm);
            so1_reg  <= som;
            neg1_reg <= neg;

            tp_reg   <= 64'(ccq_sum[63:30]) * 64'(so1_reg);
            sd2b_reg <= sd2_reg;
            so2_reg  <= so1_reg;
            neg2_reg <= neg1_reg;

            term_reg <= 64'(t_sum[63:30]) * 64'(so2_reg);
            sd2c_reg <= sd2b_reg;
            neg3_reg <= neg2_reg;

            // Clamp a to the unit interval.
            if (a_s < 0)
            begin
                a_reg <= '0;
                b_reg <= gcd_pkg::ONE_Q60;
            end
            else if (a_s > 66'(gcd_pkg::ONE_Q60))
            begin
                a_reg <= gcd_pkg::ONE_Q60;
                b_reg <= '0;
            end
            else
            begin
                a_reg <= a_s[63:0];
                b_reg <= gcd_pkg::ONE_Q60 - a_s[63:0];
            end
        end
    end

    // Square roots of a and of one minus a.
    gcd_sqrt u_sqrt_a (.clk(clk), .en(en), .radicand(a_reg), .root(sa));
    gcd_sqrt u_sqrt_b (.clk(clk), .en(en), .radicand(b_reg), .root(sb));

    // Vectoring CORDIC for atan2(sa, sb).
    for (genvar i = 0; i < NV; i++)
    begin : g_vec
        logic signed [33:0] atn;
        assign atn = 34'(gcd_pkg::ATAN_TURNS[i]);

        if (i == 0)
        begin : g_first
            assign vx_in[i] = 34'(sb);
            assign vy_in[i] = 34'(sa);
            assign vz_in[i] = '0;
        end
        else
        begin : g_next
            assign vx_in[i] = vx_reg[i-1];
            assign vy_in[i] = vy_reg[i-1];
            assign vz_in[i] = vz_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vy_in[i] > 0)
                begin
                    vx_reg[i] <= vx_in[i] + (vy_in[i] >>> i);
                    vy_reg[i] <= vy_in[i] - (vx_in[i] >>> i);
                    vz_reg[i] <= vz_in[i] + atn;
                end
                else
                begin
                    vx_reg[i] <= vx_in[i] - (vy_in[i] >>> i);
                    vy_reg[i] <= vy_in[i] + (vx_in[i] >>> i);
                    vz_reg[i] <= vz_in[i] - atn;
                end
            end
        end
    end

    // Half central angle, clamped at zero, then scaling to metres.
    always_comb
    begin
        th     = vz_reg[NV-1][33] ? 32'd0 : vz_reg[NV-1][31:0];
        cq_sum = pp_reg + (64'd1 << 28);
        d_sum  = dp_reg + (64'd1 << 29);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= 64'(th) * 64'(gcd_pkg::PI_Q29);
            dp_reg <= 64'(radius) * 64'(cq_sum[63:29]);
            if (d_sum[63:30] > 34'(gcd_pkg::DIST_MAX))
            begin
                dist_reg <= gcd_pkg::DIST_MAX;
            end
            else
            begin
                dist_reg <= d_sum[55:30];
            end
        end
    end

    assign result.valid      = vld_reg[L-1];
    assign result.distance_m = dist_reg;

endmodule

@@ tb/tb_great_circle_distance_core.sv @@
// ============================================================================
// tb_great_circle_distance_core
// Self-checking testbench of the haversine distance core. A short directed
// table under the reset radius and a long random stream of point pairs under
// several sphere radii go in. Each distance word is compared with a bit-exact
// fixed-point predictor. Both channels idle and stall at random.
// ============================================================================
module tb_great_circle_distance_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       WATCHDOG_LIMIT = 5000;
    localparam int       DRAIN_CYCLES = 130;
    localparam int       ITEMS_PER_RADIUS = 215;
    localparam longint   LAT_MAX = 94371840;
    localparam longint   LON_MAX = 188743680;
    localparam longint unsigned TURN_PER_DEG = 64'd3054198966;
    localparam longint unsigned PI_FIX = 64'd1686629713;
    localparam longint   GAIN_FIX = 652032874;
    localparam longint   QUARTER = 64'sd1073741824;
    localparam longint   HALF = 64'sd2147483648;
    localparam longint unsigned UNIT_A = 64'd1 << 60;
    localparam longint unsigned DIST_SAT = 64'd67108863;
    localparam longint   ARC_STEP [31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1
    };

    // One directed row: a point pair and, where obvious, its distance.
    typedef struct {
        logic signed [27:0] lat1;
        logic signed [28:0] lon1;
        logic signed [27:0] lat2;
        logic signed [28:0] lon2;
        bit                 known;
        logic [25:0]        fixed_m;
    } pair_row_t;

    logic clk;
    logic rst_n;

    gcd_pair_if pair_ch ();
    gcd_dist_if dist_ch ();
    gcd_cfg_if  cfg_ch ();

    great_circle_distance_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (dist_ch),
        .cfg    (cfg_ch)
    );

    logic [25:0]  dist_expected [$];
    logic [23:0]  radius_now;
    int           err_cnt;
    int           quiet_cycles;
    int           sent_cnt;
    int           got_cnt;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor of the distance.
    // ------------------------------------------------------------------
    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // Degrees times 2^20 (scaled further by sh) to a 32-bit binary angle.
    function automatic logic [31:0] to_turns(longint v, int sh);
        longint unsigned t;
        t = (abs64(v) * TURN_PER_DEG + (64'd1 << (sh - 1))) >> sh;
        if (v < 0)
            t = 64'd0 - t;
        return t[31:0];
    endfunction

    function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z = ang[31] ? longint'({32'd0, ang}) - 2 * HALF : longint'({32'd0, ang});
        flip = 1'b0;
        x = GAIN_FIX;
        y = 0;
        if (z > QUARTER)
        begin
            z -= HALF;
            flip = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            z += HALF;
            flip = 1'b1;
        end
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ARC_STEP[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ARC_STEP[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint arc_of(longint y, longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += ARC_STEP[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= ARC_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [25:0] haversine_m(logic signed [27:0] lat1,
                                                logic signed [28:0] lon1,
                                                logic signed [27:0] lat2,
                                                logic signed [28:0] lon2,
                                                logic [23:0] radius);
        longint c1, s1, c2, s2, cd, sd, co, so, a, th;
        longint unsigned ccq, t, term, sa, sb, cq, d;
        bit neg;
        rotate(to_turns(longint'(lat1), 28), c1, s1);
        rotate(to_turns(longint'(lat2), 28), c2, s2);
        rotate(to_turns(longint'(lat2) - longint'(lat1), 29), cd, sd);
        rotate(to_turns(longint'(lon2) - longint'(lon1), 29), co, so);
        // Cosines of opposite sign subtract the longitude term.
        neg = ((c1 < 0) != (c2 < 0)) && c1 != 0 && c2 != 0;
        ccq = (abs64(c1) * abs64(c2) + (64'd1 << 29)) >> 30;
        t = (ccq * abs64(so) + (64'd1 << 29)) >> 30;
        term = t * abs64(so);
        a = longint'(abs64(sd) * abs64(sd));
        a = neg ? a - longint'(term) : a + longint'(term);
        if (a < 0)
            a = 0;
        if (unsigned'(a) > UNIT_A)
            a = longint'(UNIT_A);
        sa = int_sqrt(unsigned'(a));
        sb = int_sqrt(UNIT_A - unsigned'(a));
        th = arc_of(longint'(sa), longint'(sb));
        if (th < 0)
            th = 0;
        cq = (unsigned'(th) * PI_FIX + (64'd1 << 28)) >> 29;
        d = ({40'd0, radius} * cq + (64'd1 << 29)) >> 30;
        if (d > DIST_SAT)
            d = DIST_SAT;
        return d[25:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------

    // Sends one pair word after a random gap; queues its distance on acceptance.
    task automatic send_pair(logic signed [27:0] lat1, logic signed [28:0] lon1,
                             logic signed [27:0] lat2, logic signed [28:0] lon2,
                             bit known, logic [25:0] fixed_dist);
        int gap;
        gap = (((sent_cnt / 90) % 4) == 3) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_ch.valid    <= 1'b1;
        pair_ch.ref_lat  <= lat1;
        pair_ch.ref_lon  <= lon1;
        pair_ch.comp_lat <= lat2;
        pair_ch.comp_lon <= lon2;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        dist_expected = {dist_expected,
                         known ? fixed_dist
                               : haversine_m(lat1, lon1, lat2, lon2, radius_now)};
        sent_cnt++;
    endtask

    // Lets every queued distance arrive, then the pipeline go quiet.
    task automatic drain();
        pair_ch.valid <= 1'b0;
        @(posedge clk);
        while (dist_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(logic [23:0] r);
        drain();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.sphere_radius_m <= r;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        radius_now = r;
    endtask

    function automatic logic signed [27:0] rand_lat();
        return 28'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endfunction

    function automatic logic signed [28:0] rand_lon();
        return 29'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
    endfunction

    // One random pair: mostly in range, some close together, some antipodal, some raw bits.
    task automatic send_random();
        logic signed [27:0] la1, la2;
        logic signed [28:0] lo1, lo2;
        int kind;
        kind = $urandom_range(0, 9);
        la1 = rand_lat();
        lo1 = rand_lon();
        la2 = rand_lat();
        lo2 = rand_lon();
        if (kind < 3)
        begin
            la2 = la1 + 28'(int'($urandom_range(0, 2000)) - 1000);
            lo2 = lo1 + 29'(int'($urandom_range(0, 2000)) - 1000);
        end
        else if (kind == 3)
        begin
            la2 = -la1;
            lo2 = lo1 + 29'(LON_MAX);
        end
        else if (kind == 4)
        begin
            la1 = 28'($urandom());
            lo1 = 29'($urandom());
            la2 = 28'($urandom());
            lo2 = 29'($urandom());
        end
        send_pair(la1, lo1, la2, lo2, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        pair_row_t rows [$];
        logic [23:0] radii [$];
        pair_ch.valid           <= 1'b0;
        pair_ch.ref_lat         <= '0;
        pair_ch.ref_lon         <= '0;
        pair_ch.comp_lat        <= '0;
        pair_ch.comp_lon        <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.sphere_radius_m  <= '0;
        rst_n                   <= 1'b0;
        err_cnt = 0;
        sent_cnt = 0;
        radius_now = 24'd6371000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identical points give zero; the rest go to the predictor.
        rows = '{
            '{28'sd0, 29'sd0, 28'sd0, 29'sd0, 1'b1, 26'd0},
            '{28'sd94371840, 29'sd188743680, 28'sd94371840, 29'sd188743680, 1'b1, 26'd0},
            '{-28'sd94371840, -29'sd188743680, -28'sd94371840, -29'sd188743680, 1'b1, 26'd0},
            '{28'sd94371840, 29'sd0, -28'sd94371840, 29'sd0, 1'b0, 26'd0},
            '{28'sd0, 29'sd0, 28'sd0, 29'sd188743680, 1'b0, 26'd0},
            '{28'sd0, -29'sd188743680, 28'sd0, 29'sd188743680, 1'b0, 26'd0},
            '{28'sd0, 29'sd0, 28'sd0, 29'sd94371840, 1'b0, 26'd0},
            '{28'sd1, 29'sd0, 28'sd0, 29'sd1, 1'b0, 26'd0},
            '{28'sh7FFFFFF, 29'sh0FFFFFFF, 28'sh8000000, 29'sh10000000, 1'b0, 26'd0},
            '{28'sh8000000, 29'sh10000000, 28'sh7FFFFFF, 29'sh0FFFFFFF, 1'b0, 26'd0},
            '{28'sd125829120, 29'sd0, 28'sd0, 29'sd0, 1'b0, 26'd0},
            '{28'sd125829120, 29'sd0, -28'sd62914560, 29'sd0, 1'b0, 26'd0},
            '{28'sd0, 29'sd0, 28'sd0, 29'sd251658240, 1'b0, 26'd0},
            '{28'sd41943040, 29'sd10485760, 28'sd52428800, -29'sd78643200, 1'b0, 26'd0},
            '{-28'sd1, -29'sd1, 28'sd1, 29'sd1, 1'b0, 26'd0},
            '{28'sd50000000, 29'sd100000000, -28'sd50000000, -29'sd88743680, 1'b0, 26'd0}
        };
        foreach (rows[i])
            send_pair(rows[i].lat1, rows[i].lon1, rows[i].lat2, rows[i].lon2,
                      rows[i].known, rows[i].fixed_m);

        // Random pairs under the reset radius, then under each written radius.
        radii = '{24'd0, 24'd1, 24'hFFFFFF, 24'($urandom_range(2, 16777214)), 24'd6371000};
        for (int i = 0; i < ITEMS_PER_RADIUS; i++)
            send_random();
        foreach (radii[k])
        begin
            write_radius(radii[k]);
            for (int i = 0; i < ITEMS_PER_RADIUS; i++)
                send_random();
        end

        drain();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, with stretches of none.
    initial
    begin
        int stall;
        got_cnt = 0;
        dist_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = (((got_cnt / 70) % 4) == 1) ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                dist_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dist_ch.ready <= 1'b1;
            @(posedge clk);
            while (!dist_ch.valid)
                @(posedge clk);
            got_cnt++;
        end
    end

    // Distance checker.
    always @(posedge clk)
    begin
        logic [25:0] want;
        if (rst_n && dist_ch.valid && dist_ch.ready)
        begin
            if (dist_expected.size() == 0)
            begin
                $error("distance_m: no word expected, got %0d", dist_ch.distance_m);
                err_cnt++;
            end
            else
            begin
                want = dist_expected.pop_front();
                if (dist_ch.distance_m !== want)
                begin
                    $error("distance_m: expected %0d, got %0d", want, dist_ch.distance_m);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if (!rst_n || (pair_ch.valid && pair_ch.ready) || (dist_ch.valid && dist_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
